// ===== rtl/clint_pkg.sv =====
// ----------------------------------------------------------------------------
// Core-local interruptor package
// Shared constants, request and response types and the decoded access record.
// ----------------------------------------------------------------------------
package clint_pkg;

   localparam int NUM_HARTS = 8;
   localparam int HART_W    = (NUM_HARTS > 1) ? $clog2(NUM_HARTS) : 1;
   localparam int IDX_W     = 12;
   localparam int IRQ_W     = 8;
   localparam int DATA_W    = 64;
   localparam int OFF_W     = 16;

   localparam logic [IDX_W-1:0] HART_LIMIT = IDX_W'(NUM_HARTS);
   localparam logic [OFF_W-1:0] TIME_ADDR  = 16'hbff8;
   localparam logic [12:0]      CMP_BASE_DW = 13'h0800;
   localparam logic [DATA_W-1:0] CMP_NONE = {DATA_W{1'b1}};

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_READ  = 2'd1,
      OP_WRITE = 2'd2,
      OP_SWAP  = 2'd3
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [OFF_W-1:0]   offset;
      logic               wide;
      logic [DATA_W-1:0]  wdata;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]  rdata;
      logic               bad_access;
      logic [IRQ_W-1:0]   soft_irq;
      logic [IRQ_W-1:0]   timer_irq;
   } rsp_type;

   typedef struct packed {
      logic              tick;
      logic              soft_sel;
      logic              cmp_sel;
      logic              time_rd;
      logic              bad;
      logic              rd;
      logic              wr;
      logic [HART_W-1:0] hart;
   } access_type;

endpackage

// ===== rtl/clint_decode.sv =====
// ----------------------------------------------------------------------------
// Core-local interruptor address decoder
// Classifies a request by region, checks size, alignment and hart range.
// ----------------------------------------------------------------------------
module clint_decode (
   input  clint_pkg::req_type    req,
   output clint_pkg::access_type access
);

   logic [clint_pkg::IDX_W-1:0] soft_idx;
   logic [12:0]                 cmp_idx;
   logic                        soft_ok;
   logic                        cmp_ok;

   assign soft_idx = req.offset[13:2];
   assign cmp_idx  = req.offset[15:3] - clint_pkg::CMP_BASE_DW;
   assign soft_ok  = !req.wide && (req.offset[1:0] == 2'b00)
                     && (soft_idx < clint_pkg::HART_LIMIT);
   assign cmp_ok   = req.wide && (req.offset[2:0] == 3'b000)
                     && (cmp_idx[clint_pkg::IDX_W-1:0] < clint_pkg::HART_LIMIT);

   always_comb begin
      access          = '0;
      access.rd       = (req.op == clint_pkg::OP_READ) || (req.op == clint_pkg::OP_SWAP);
      access.wr       = (req.op == clint_pkg::OP_WRITE) || (req.op == clint_pkg::OP_SWAP);
      if (req.op == clint_pkg::OP_TICK) begin
         access.tick = 1'b1;
         access.rd   = 1'b0;
      end else if (req.offset[15:14] == 2'b00) begin
         access.hart     = soft_idx[clint_pkg::HART_W-1:0];
         access.soft_sel = soft_ok;
         access.bad      = !soft_ok;
      end else if (req.offset < clint_pkg::TIME_ADDR) begin
         access.hart    = cmp_idx[clint_pkg::HART_W-1:0];
         access.cmp_sel = cmp_ok;
         access.bad     = !cmp_ok;
      end else if ((req.offset == clint_pkg::TIME_ADDR) && req.wide
                   && (req.op == clint_pkg::OP_READ)) begin
         access.time_rd = 1'b1;
      end else begin
         access.bad = 1'b1;
      end
   end

endmodule

// ===== rtl/clint_state.sv =====
// ----------------------------------------------------------------------------
// Core-local interruptor state
// Software-interrupt bits, timer compare values, the time counter and the
// per-hart interrupt lines derived from them.
// ----------------------------------------------------------------------------
module clint_state (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              valid,
   input  clint_pkg::access_type             access,
   input  logic [clint_pkg::DATA_W-1:0]      wdata,
   output logic [clint_pkg::DATA_W-1:0]      rdata,
   output logic [clint_pkg::IRQ_W-1:0]       soft_irq,
   output logic [clint_pkg::IRQ_W-1:0]       timer_irq
);

   logic [clint_pkg::NUM_HARTS-1:0] soft_ff;
   logic [clint_pkg::NUM_HARTS-1:0] soft_in;
   logic [clint_pkg::DATA_W-1:0]    compare_ff [clint_pkg::NUM_HARTS];
   logic [clint_pkg::DATA_W-1:0]    time_ff;
   logic [clint_pkg::DATA_W-1:0]    time_in;
   logic                            soft_we;
   logic                            cmp_we;

   assign soft_we = valid && access.soft_sel && access.wr;
   assign cmp_we  = valid && access.cmp_sel && access.wr;

   always_comb begin
      soft_in = soft_ff;
      if (soft_we) begin
         soft_in[access.hart] = wdata[0];
      end
      time_in = time_ff;
      if (valid && access.tick) begin
         time_in = time_ff + 64'd1;
      end
   end

   always_comb begin
      rdata = '0;
      if (access.rd) begin
         if (access.soft_sel) begin
            rdata = {{(clint_pkg::DATA_W-1){1'b0}}, soft_ff[access.hart]};
         end else if (access.cmp_sel) begin
            rdata = compare_ff[access.hart];
         end else if (access.time_rd) begin
            rdata = time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_ff <= '0;
         time_ff <= '0;
         for (int h = 0; h < clint_pkg::NUM_HARTS; h++) begin
            compare_ff[h] <= clint_pkg::CMP_NONE;
         end
      end else begin
         soft_ff <= soft_in;
         time_ff <= time_in;
         if (cmp_we) begin
            compare_ff[access.hart] <= wdata;
         end
      end
   end

   for (genvar h = 0; h < clint_pkg::IRQ_W; h++) begin : g_irq
      if (h < clint_pkg::NUM_HARTS) begin : g_on
         assign soft_irq[h]  = soft_ff[h];
         assign timer_irq[h] = (time_ff >= compare_ff[h]);
      end else begin : g_off
         assign soft_irq[h]  = 1'b0;
         assign timer_irq[h] = 1'b0;
      end
   end

   a_tick_advances: assert property (@(posedge clock) disable iff (reset)
      valid && access.tick |=> time_ff == $past(time_ff) + 64'd1)
      else $error("time counter did not advance on a tick");

   a_time_holds: assert property (@(posedge clock) disable iff (reset)
      !(valid && access.tick) |=> $stable(time_ff))
      else $error("time counter moved without a tick");

   a_bad_no_effect: assert property (@(posedge clock) disable iff (reset)
      valid && access.bad |=> $stable(soft_ff) && $stable(time_ff))
      else $error("flagged access changed state");

   a_one_target: assert property (@(posedge clock) disable iff (reset)
      valid |-> $onehot0({access.tick, access.soft_sel, access.cmp_sel,
                          access.time_rd, access.bad}))
      else $error("request decoded to more than one target");

endmodule

// ===== rtl/core_local_interruptor.sv =====
// ----------------------------------------------------------------------------
// Core-local interruptor
// A request is a time tick or one read, write or swap of a software-interrupt
// bit, a timer compare value or the time counter; every request gives one
// response with read data, an error flag and the per-hart interrupt lines.
// ----------------------------------------------------------------------------
// A request is taken in any cycle in which start is high and busy is low, so
// one request per cycle is sustained. Busy is high during reset and in the
// first cycle after it. The request is registered at acceptance, decoded in
// the next cycle and applied to the state at the end of that cycle. The same
// edge loads the response, which is on rsp with rsp_valid high for exactly
// one cycle. The receiver cannot stall the response, and the interrupt
// lines show the state after the request.
module core_local_interruptor (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  clint_pkg::req_type   req,
   output logic                 rsp_valid,
   output clint_pkg::rsp_type   rsp
);

   logic                              busy_ff;
   logic                              req_valid_ff;
   logic                              req_valid_in;
   clint_pkg::req_type                req_ff;
   logic                              rsp_valid_ff;
   logic [clint_pkg::DATA_W-1:0]      rsp_rdata_ff;
   logic                              rsp_bad_ff;
   clint_pkg::access_type             access;
   logic [clint_pkg::DATA_W-1:0]      rdata;
   logic [clint_pkg::IRQ_W-1:0]       soft_irq;
   logic [clint_pkg::IRQ_W-1:0]       timer_irq;

   assign req_valid_in = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req;
      end
      rsp_rdata_ff <= rdata;
      rsp_bad_ff   <= access.bad;
   end

   clint_decode u_decode (
      .req    (req_ff),
      .access (access)
   );

   clint_state u_state (
      .clock     (clock),
      .reset     (reset),
      .valid     (req_valid_ff),
      .access    (access),
      .wdata     (req_ff.wdata),
      .rdata     (rdata),
      .soft_irq  (soft_irq),
      .timer_irq (timer_irq)
   );

   assign busy               = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp.rdata          = rsp_rdata_ff;
   assign rsp.bad_access     = rsp_bad_ff;
   assign rsp.soft_irq       = soft_irq;
   assign rsp.timer_irq      = timer_irq;

endmodule
